// File: hw/rtl/exp_taylor_series_unit_assert.svh
// Assertion macros for the exp Taylor series unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef EXP_TAYLOR_SERIES_UNIT_ASSERT_SVH
`define EXP_TAYLOR_SERIES_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define ETS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the following cycle
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ets_pkg.sv
// Shared types and constants for the exp Taylor series unit.
// No dependencies.
package ets_pkg;

  localparam int PROD_W    = 88;   // term magnitude (63b) times |x| (24b), rounded up to x8
  localparam int DIV_BITS  = 8;    // quotient bits per cycle in the term divider
  localparam int DIV_STEPS = PROD_W / DIV_BITS;
  localparam int RCP_W     = 64;
  localparam logic [63:0] SAT_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic               op;
    logic signed [23:0] arg_value;
    logic        [7:0]  term_count;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] approx_value;
    logic               overflow_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_TERM,
    ST_SUM,
    ST_RCP_INIT,
    ST_RCP,
    ST_FINISH
  } ets_state_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic term_upd;
    logic sum_upd;
    logic rcp_init;
    logic rcp_step;
    logic out_load;
  } ets_cmd_t;

  typedef struct packed {
    logic op;
    logic cnt_zero;
    logic series_last;
    logic div_done;
    logic rcp_done;
  } ets_status_t;

endpackage

// File: hw/rtl/ets_ctrl.sv
// Controller FSM for the exp Taylor series unit.
// Depends on ets_pkg; drives the command struct of ets_datapath.
module ets_ctrl import ets_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ets_status_t status,
  output ets_cmd_t    cmd
);

  ets_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_START;
      ST_START: begin
        if (!status.cnt_zero) state_nxt = ST_MUL_LO;
        else if (status.op)   state_nxt = ST_RCP_INIT;
        else                  state_nxt = ST_FINISH;
      end
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_DIV;
      ST_DIV:      if (status.div_done) state_nxt = ST_TERM;
      ST_TERM:     state_nxt = ST_SUM;
      ST_SUM: begin
        if (!status.series_last) state_nxt = ST_MUL_LO;
        else if (status.op)      state_nxt = ST_RCP_INIT;
        else                     state_nxt = ST_FINISH;
      end
      ST_RCP_INIT: state_nxt = ST_RCP;
      ST_RCP:      if (status.rcp_done) state_nxt = ST_FINISH;
      ST_FINISH:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_LO:   cmd.mul_lo   = 1'b1;
      ST_MUL_HI:   cmd.mul_hi   = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_TERM:     cmd.term_upd = 1'b1;
      ST_SUM:      cmd.sum_upd  = 1'b1;
      ST_RCP_INIT: cmd.rcp_init = 1'b1;
      ST_RCP:      cmd.rcp_step = 1'b1;
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ets_datapath.sv
// Datapath for the exp Taylor series unit: shared 32x24 multiplier, radix-256
// term divider, sign-magnitude accumulator, bit-serial reciprocal divider.
// Depends on ets_pkg; sequenced by ets_ctrl.
module ets_datapath import ets_pkg::*; #(
  parameter int MAX_TERMS = 255,
  parameter int FRAC_BITS = 18
) (
  input  logic        clk,
  input  in_item_t    in_data,
  input  ets_cmd_t    cmd,
  output ets_status_t status,
  output out_item_t   out_data
);

  localparam int NW = $clog2(MAX_TERMS + 1);

  logic              op_r;
  logic              xneg_r;
  logic [23:0]       mx_r;
  logic [NW-1:0]     count_r;
  logic [NW-1:0]     n_r;
  logic [63:0]       tmag_r;
  logic              tneg_r;
  logic [63:0]       smag_r;
  logic              sneg_r;
  logic              ovf_r;
  logic [PROD_W-1:0] prod_r;
  logic [NW-1:0]     rem_r;
  logic [3:0]        div_cnt_r;
  logic [63:0]       rq_r;
  logic [63:0]       rr_r;
  logic [5:0]        rcp_cnt_r;
  out_item_t         out_r;

  // load
  logic [NW-1:0] cnt_clamp;
  assign cnt_clamp = (32'(in_data.term_count) > 32'(MAX_TERMS)) ?
                     NW'(MAX_TERMS) : NW'(in_data.term_count);

  // one half of the term magnitude per cycle
  logic [31:0] mul_a;
  logic [55:0] mul_p;
  assign mul_a = cmd.mul_hi ? tmag_r[63:32] : tmag_r[31:0];
  assign mul_p = 56'(mul_a) * 56'(mx_r);

  // eight restoring steps of the division by n
  logic [PROD_W-1:0] div_nxt;
  logic [NW-1:0]     div_rem;
  always_comb begin
    logic [NW:0]         trial;
    logic [DIV_BITS-1:0] qb;
    div_rem = rem_r;
    qb      = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {div_rem, prod_r[PROD_W-1-i]};
      if (trial >= {1'b0, n_r}) begin
        trial         = trial - {1'b0, n_r};
        qb[DIV_BITS-1-i] = 1'b1;
      end
      div_rem = trial[NW-1:0];
    end
    div_nxt = {prod_r[PROD_W-DIV_BITS-1:0], qb};
  end

  // new term from the quotient
  logic [PROD_W-1:0] q_shift;
  logic              t_ovf;
  logic [63:0]       t_new;
  assign q_shift = prod_r >> FRAC_BITS;
  assign t_ovf   = |q_shift[PROD_W-1:63];
  assign t_new   = t_ovf ? SAT_LIM : {1'b0, q_shift[62:0]};

  // sign-magnitude accumulate
  logic [63:0] s_new;
  logic        sn_new;
  logic        s_ovf;
  always_comb begin
    s_ovf  = 1'b0;
    sn_new = sneg_r;
    if (tneg_r == sneg_r) begin
      if (smag_r > SAT_LIM - tmag_r) begin
        s_new = SAT_LIM;
        s_ovf = 1'b1;
      end else begin
        s_new = smag_r + tmag_r;
      end
    end else if (smag_r >= tmag_r) begin
      s_new = smag_r - tmag_r;
    end else begin
      s_new  = tmag_r - smag_r;
      sn_new = tneg_r;
    end
    if (s_new == '0) sn_new = 1'b0;
  end

  // reciprocal: one quotient bit per cycle
  logic [64:0] r_trial;
  logic        r_fit;
  assign r_trial = {rr_r, rq_r[63]};
  assign r_fit   = r_trial >= {1'b0, smag_r};

  logic [63:0] rcp_num;
  assign rcp_num = (64'(1) << (2 * FRAC_BITS)) + (smag_r >> 1);

  logic [63:0] mag_out;
  logic        zero_div;
  assign zero_div = op_r && (smag_r == '0);
  assign mag_out  = op_r ? rq_r : smag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      xneg_r  <= in_data.arg_value[23];
      mx_r    <= in_data.arg_value[23] ? 24'(-in_data.arg_value) : in_data.arg_value;
      count_r <= cnt_clamp;
      n_r     <= NW'(1);
      tmag_r  <= 64'(1) << FRAC_BITS;
      tneg_r  <= 1'b0;
      smag_r  <= 64'(1) << FRAC_BITS;
      sneg_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end
    if (cmd.mul_lo) prod_r <= PROD_W'(mul_p);
    if (cmd.mul_hi) begin
      prod_r    <= prod_r + (PROD_W'(mul_p) << 32);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      prod_r    <= div_nxt;
      rem_r     <= div_rem;
      div_cnt_r <= div_cnt_r + 4'd1;
    end
    if (cmd.term_upd) begin
      tmag_r <= t_new;
      tneg_r <= (tneg_r ^ xneg_r) && (t_new != '0);
      if (t_ovf) ovf_r <= 1'b1;
    end
    if (cmd.sum_upd) begin
      smag_r <= s_new;
      sneg_r <= sn_new;
      n_r    <= n_r + NW'(1);
      if (s_ovf) ovf_r <= 1'b1;
    end
    if (cmd.rcp_init) begin
      rq_r      <= rcp_num;
      rr_r      <= '0;
      rcp_cnt_r <= '0;
    end
    if (cmd.rcp_step) begin
      rr_r      <= r_fit ? 64'(r_trial - {1'b0, smag_r}) : r_trial[63:0];
      rq_r      <= {rq_r[62:0], r_fit};
      rcp_cnt_r <= rcp_cnt_r + 6'd1;
    end
    if (cmd.out_load) begin
      out_r.approx_value  <= zero_div ? SAT_LIM : (sneg_r ? -mag_out : mag_out);
      out_r.overflow_flag <= ovf_r || zero_div;
    end
  end

  assign status.op          = op_r;
  assign status.cnt_zero    = (count_r == '0);
  assign status.series_last = (n_r == count_r) || (tmag_r == '0);
  assign status.div_done    = (div_cnt_r == 4'(DIV_STEPS - 1));
  assign status.rcp_done    = (rcp_cnt_r == 6'(RCP_W - 1));
  assign out_data           = out_r;

endmodule

// File: hw/rtl/exp_taylor_series_unit.sv
// Top level of the exp Taylor series unit: ets_ctrl plus ets_datapath.
// Depends on ets_pkg, ets_ctrl, ets_datapath.
//
// Evaluates sum(x^n/n!, n=0..N) one term at a time (term = term*x/n), and with
// op=1 returns its reciprocal. One item is in flight at a time. The number of terms
// evaluated is N clamped to MAX_TERMS, or fewer once a term truncates to zero.
// Each term passes through the shared 32x24 multiplier (low half, then high half),
// the divider by n (8 quotient bits per cycle over an 88-bit product) and then the
// term update and the sum update; for op=1 the reciprocal follows, a setup step and
// then the one-bit divider steps. A finished result sits in an output register,
// so the next item can be accepted while it waits.
module exp_taylor_series_unit import ets_pkg::*; #(
  parameter int MAX_TERMS = 255,
  parameter int FRAC_BITS = 18
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ets_cmd_t    cmd;
  ets_status_t status;

  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ets_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// File: hw/rtl/ets_checker.sv
// Port-level checks for exp_taylor_series_unit, bound to the top level.
// Depends on ets_pkg and exp_taylor_series_unit_assert.svh.
`include "exp_taylor_series_unit_assert.svh"

module ets_checker import ets_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `ETS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ETS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `ETS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second transaction taken while busy")
  `ETS_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind exp_taylor_series_unit ets_checker u_ets_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb_exp_taylor_series_unit.sv
// Self-checking testbench for exp_taylor_series_unit: directed and random
// transactions, a wide-integer series predictor and in-order result checking.
// Depends on ets_pkg and the exp_taylor_series_unit RTL.
module tb_exp_taylor_series_unit;
  import ets_pkg::*;

  localparam int MAX_N = 255;
  localparam int FRAC  = 18;
  localparam int TAIL_CYCLES = 4200;  // longest single evaluation plus margin

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t   pending_items[$];
  out_item_t  expected_approx[$];
  idle_mode_t mode = IDLE_NONE;
  bit         rx_hold = 1'b0;
  int         sent_seen = 0;
  int         n_sent = 0, n_checked = 0, n_errors = 0, n_ovf = 0, n_rcp = 0;

  exp_taylor_series_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic out_item_t exp_series(in_item_t it);
    logic [127:0] prod;
    logic [63:0]  tmag, smag, mx, q;
    logic         tneg, sneg, xneg, ovf;
    int           cnt;
    out_item_t    r;
    xneg = it.arg_value[23];
    mx   = xneg ? (64'h100_0000 - {40'b0, it.arg_value}) : {40'b0, it.arg_value};
    tmag = 64'd1 << FRAC;
    smag = tmag;
    tneg = 1'b0;
    sneg = 1'b0;
    ovf  = 1'b0;
    cnt  = it.term_count;
    if (cnt > MAX_N) cnt = MAX_N;
    for (int n = 1; n <= cnt; n++) begin
      prod = ({64'b0, tmag} * {64'b0, mx}) >> FRAC;
      prod = prod / n;
      if (prod > {64'b0, SAT_LIM}) begin
        tmag = SAT_LIM;
        ovf  = 1'b1;
      end else begin
        tmag = prod[63:0];
      end
      tneg = (tneg != xneg) && (tmag != 0);
      if (tneg == sneg) begin
        if (smag > SAT_LIM - tmag) begin
          smag = SAT_LIM;
          ovf  = 1'b1;
        end else begin
          smag = smag + tmag;
        end
      end else if (smag >= tmag) begin
        smag = smag - tmag;
      end else begin
        smag = tmag - smag;
        sneg = tneg;
      end
      if (smag == 0) sneg = 1'b0;
    end
    if (!it.op) begin
      r.approx_value = sneg ? -smag : smag;
    end else if (smag == 0) begin
      r.approx_value = SAT_LIM;
      ovf = 1'b1;
    end else begin
      q = ((64'd1 << (2 * FRAC)) + smag / 2) / smag;
      r.approx_value = sneg ? -q : q;
    end
    r.overflow_flag = ovf;
    return r;
  endfunction

  function automatic in_item_t make_item(bit op, logic [23:0] x, logic [7:0] n);
    in_item_t it;
    it.op = op;
    it.arg_value = x;
    it.term_count = n;
    return it;
  endfunction

  // Most items keep N small so the run stays short; a few go to the top.
  function automatic in_item_t rand_item();
    in_item_t it;
    int       sel;
    it.op = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 50)
      it.arg_value = 24'(($signed(32'($urandom_range(0, 24'h7F_FFFF))) - 32'sh40_0000) >>> 3);
    else it.arg_value = 24'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 80) it.term_count = 8'($urandom_range(0, 20));
    else if (sel < 96) it.term_count = 8'($urandom_range(21, 60));
    else it.term_count = 8'($urandom_range(61, 255));
    return it;
  endfunction

  function automatic bit idle_roll(bit recv_side);
    int pct;
    case (mode)
      IDLE_SEND: pct = recv_side ? 0 : 54;
      IDLE_RECV: pct = recv_side ? 54 : 0;
      IDLE_BOTH: pct = 32;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: acceptance seen at posedge, next payload presented at negedge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_approx.push_back(exp_series(in_data));
      n_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || n_sent != sent_seen)) begin
      if (pending_items.size() > 0 && !idle_roll(1'b0)) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    sent_seen = n_sent;
    out_ready <= rst_n && !rx_hold && !idle_roll(1'b1);
  end

  // Monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_approx.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction: %h", out_data);
      end else begin
        want = expected_approx.pop_front();
        n_checked++;
        if (want.overflow_flag) n_ovf++;
        if (out_data !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: approx exp %h got %h, ovf exp %b got %b", n_checked,
                     want.approx_value, out_data.approx_value, want.overflow_flag,
                     out_data.overflow_flag);
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_approx.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(idle_mode_t m, int count);
    mode = m;
    for (int i = 0; i < count; i++) begin
      in_item_t it;
      it = rand_item();
      if (it.op) n_rcp++;
      pending_items.push_back(it);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners, both ops each
    for (int op = 0; op < 2; op++) begin
      bit opb;
      opb = 1'(op);
      pending_items.push_back(make_item(opb, 24'h00_0000, 8'd0));
      pending_items.push_back(make_item(opb, 24'h00_0000, 8'd255));
      pending_items.push_back(make_item(opb, 24'h04_0000, 8'd30));
      pending_items.push_back(make_item(opb, 24'hFC_0000, 8'd1));  // sum exactly zero
      pending_items.push_back(make_item(opb, 24'hFC_0000, 8'd40));
      pending_items.push_back(make_item(opb, 24'h7F_FFFF, 8'd255)); // saturation
      pending_items.push_back(make_item(opb, 24'h80_0000, 8'd255));
      pending_items.push_back(make_item(opb, 24'h80_0000, 8'd3));
      pending_items.push_back(make_item(opb, 24'h00_0001, 8'd2));
      pending_items.push_back(make_item(opb, 24'hFF_FFFF, 8'd2));
      pending_items.push_back(make_item(opb, 24'h28_0000, 8'd200));
    end
    n_rcp += 11;
    drain();
    run_phase(IDLE_NONE, 350);
    run_phase(IDLE_SEND, 350);
    // long receiver hold-off while items keep coming
    mode = IDLE_NONE;
    for (int i = 0; i < 40; i++) begin
      in_item_t it;
      it = rand_item();
      if (it.op) n_rcp++;
      pending_items.push_back(it);
    end
    rx_hold = 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold = 1'b0;
    drain();
    run_phase(IDLE_RECV, 350);
    run_phase(IDLE_BOTH, 350);
    run_phase(IDLE_NONE, 300);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_approx.size() > 0) n_errors++;
    $display("%0d transactions sent, %0d results checked (%0d reciprocal ops, %0d overflow).",
             n_sent, n_checked, n_rcp, n_ovf);
    $display("phases: no idling, sender gaps, receiver stalls, both, long hold-off; errors %0d",
             n_errors);
    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(8 * 8_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
